// ===== rtl/core/length_prefixed_deframer_assert.svh =====
// Assertion macros for the deframer RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef LENGTH_PREFIXED_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_DEFRAMER_ASSERT_SVH

// Same-cycle implication.
`define LPD_ASSERT_IMPL(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("lpd assertion failed");

// Next-cycle implication.
`define LPD_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("lpd assertion failed");

`endif

// ===== rtl/core/lpd_pkg.sv =====
// Package for the length-prefixed deframer: codes, widths and reset values.
// No dependencies; used by length_prefixed_deframer.
package lpd_pkg;

    localparam int unsigned CFG_INDEX_W   = 1;
    localparam int unsigned CFG_DATA_W    = 32;
    localparam int unsigned LEN_W         = 32;
    localparam int unsigned TIMEOUT_W     = 16;
    localparam int unsigned HDR_W         = 24;

    localparam logic [LEN_W-1:0]     MAX_PAYLOAD_RESET     = 32'd65536;
    localparam logic [TIMEOUT_W-1:0] PAYLOAD_TIMEOUT_RESET = 16'd5000;
    localparam logic [LEN_W-1:0]     HEADER_LEN            = 32'd4;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD     = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAYLOAD_TIMEOUT = 1'd1;

    typedef enum logic [1:0] {
        OP_BYTE    = 2'd0,
        OP_TICK    = 2'd1,
        OP_CONNECT = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        PH_DISC = 2'd0,
        PH_HEAD = 2'd1,
        PH_PAY  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_DATA     = 2'd0,
        ST_TOO_LONG = 2'd1,
        ST_ZERO     = 2'd2,
        ST_TIMEOUT  = 2'd3
    } status_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] data;
        logic       last;
    } result_t;

endpackage

// ===== rtl/core/length_prefixed_deframer.sv =====
// Length-prefixed deframer. Takes one transaction per cycle (a received byte, a
// time tick or a connect) and returns the payload byte or error it causes, if
// any, in the next cycle from an output register. in_stall rises only while that
// register is full and the consumer stalls; else a stream runs at one item per
// clock. Each message is a 4-byte big-endian length that counts itself, then
// the payload; an oversize or empty payload, or too many ticks between payload
// bytes, reports an error and drops the link until the next connect. Config
// writes are always taken (cfg_ready is tied high).
// Depends on lpd_pkg and length_prefixed_deframer_assert.svh.
module length_prefixed_deframer
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         operation,
    input  logic [7:0]                         rx_byte,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         status,
    output logic [7:0]                         payload_byte,
    output logic                               last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lpd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lpd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import lpd_pkg::*;

    `include "length_prefixed_deframer_assert.svh"

    logic [LEN_W-1:0]     max_payload_reg;
    logic [TIMEOUT_W-1:0] payload_timeout_reg;

    phase_t               phase_reg, phase_next;
    logic [1:0]           hdr_cnt_reg, hdr_cnt_next;
    logic [HDR_W-1:0]     hdr_bytes_reg, hdr_bytes_next;
    logic [LEN_W-1:0]     bytes_left_reg, bytes_left_next;
    logic [TIMEOUT_W-1:0] idle_reg, idle_next;

    logic                 out_valid_reg, out_valid_next;
    result_t              result_reg, result_next;

    logic                 in_fire;
    logic                 res_valid;
    result_t              res;
    logic [LEN_W-1:0]     len;
    logic [TIMEOUT_W:0]   idle_inc;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign in_fire   = in_valid && !in_stall;

    assign len      = {hdr_bytes_reg, rx_byte} - HEADER_LEN;
    assign idle_inc = {1'b0, idle_reg} + {{TIMEOUT_W{1'b0}}, 1'b1};

    always_comb
    begin
        phase_next      = phase_reg;
        hdr_cnt_next    = hdr_cnt_reg;
        hdr_bytes_next  = hdr_bytes_reg;
        bytes_left_next = bytes_left_reg;
        idle_next       = idle_reg;
        res_valid       = 1'b0;
        res.status      = ST_DATA;
        res.data        = 8'd0;
        res.last        = 1'b0;

        case (operation)
            OP_CONNECT:
            begin
                if (phase_reg == PH_DISC)
                begin
                    phase_next      = PH_HEAD;
                    hdr_cnt_next    = 2'd0;
                    hdr_bytes_next  = '0;
                    bytes_left_next = '0;
                    idle_next       = '0;
                end
            end
            OP_TICK:
            begin
                if (phase_reg == PH_PAY)
                begin
                    // The sum is one bit wider so a full 16-bit count still compares.
                    if (idle_inc >= {1'b0, payload_timeout_reg})
                    begin
                        phase_next      = PH_DISC;
                        bytes_left_next = '0;
                        idle_next       = '0;
                        res_valid       = 1'b1;
                        res.status      = ST_TIMEOUT;
                    end
                    else
                    begin
                        idle_next = idle_inc[TIMEOUT_W-1:0];
                    end
                end
            end
            OP_BYTE:
            begin
                if (phase_reg == PH_HEAD)
                begin
                    if (hdr_cnt_reg != 2'd3)
                    begin
                        hdr_bytes_next = {hdr_bytes_reg[HDR_W-9:0], rx_byte};
                        hdr_cnt_next   = hdr_cnt_reg + 2'd1;
                    end
                    else
                    begin
                        hdr_cnt_next   = 2'd0;
                        hdr_bytes_next = '0;
                        idle_next      = '0;
                        // A length under four wraps here and fails as too long unless the limit is that high.
                        if (len > max_payload_reg)
                        begin
                            phase_next = PH_DISC;
                            res_valid  = 1'b1;
                            res.status = ST_TOO_LONG;
                        end
                        else if (len == '0)
                        begin
                            phase_next = PH_DISC;
                            res_valid  = 1'b1;
                            res.status = ST_ZERO;
                        end
                        else
                        begin
                            phase_next      = PH_PAY;
                            bytes_left_next = len;
                        end
                    end
                end
                else if (phase_reg == PH_PAY)
                begin
                    res_valid = 1'b1;
                    res.data  = rx_byte;
                    res.last  = (bytes_left_reg <= {{(LEN_W-1){1'b0}}, 1'b1});
                    idle_next = '0;
                    if (res.last)
                    begin
                        phase_next      = PH_HEAD;
                        bytes_left_next = '0;
                    end
                    else
                    begin
                        bytes_left_next = bytes_left_reg - {{(LEN_W-1){1'b0}}, 1'b1};
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        if (in_fire && res_valid)
        begin
            out_valid_next = 1'b1;
            result_next    = res;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg     <= MAX_PAYLOAD_RESET;
            payload_timeout_reg <= PAYLOAD_TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_MAX_PAYLOAD)
            begin
                max_payload_reg <= cfg_data;
            end
            if (cfg_index == CFG_PAYLOAD_TIMEOUT)
            begin
                payload_timeout_reg <= cfg_data[TIMEOUT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_DISC;
            hdr_cnt_reg    <= 2'd0;
            hdr_bytes_reg  <= '0;
            bytes_left_reg <= '0;
            idle_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg      <= phase_next;
                hdr_cnt_reg    <= hdr_cnt_next;
                hdr_bytes_reg  <= hdr_bytes_next;
                bytes_left_reg <= bytes_left_next;
                idle_reg       <= idle_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = result_reg.status;
    assign payload_byte = result_reg.data;
    assign last         = result_reg.last;

    `LPD_ASSERT_NEXT(a_error_drops_link, in_fire && res_valid && res.status != ST_DATA, phase_reg == PH_DISC)
    `LPD_ASSERT_NEXT(a_last_rearms_header, in_fire && res_valid && res.last, phase_reg == PH_HEAD)
    `LPD_ASSERT_IMPL(a_payload_pending, phase_reg == PH_PAY, bytes_left_reg != '0)
    `LPD_ASSERT_IMPL(a_header_idle, phase_reg != PH_HEAD, hdr_cnt_reg == 2'd0)

endmodule

// ===== tb/lpd_checker.sv =====
// Checker for the length-prefixed deframer: watches the input, result and register
// channels, predicts each result and compares it. Depends on lpd_pkg only.
module lpd_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [1:0]                       operation,
    input  logic [7:0]                       rx_byte,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [1:0]                       status,
    input  logic [7:0]                       payload_byte,
    input  logic                             last,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [lpd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lpd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                               error_count,
    output int                               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import lpd_pkg::*;

    logic [31:0] max_len;
    logic [15:0] tick_limit;

    phase_t      link_phase;
    logic [1:0]  hdr_count;
    logic [23:0] hdr_bytes;
    logic [31:0] bytes_left;
    logic [16:0] idle_ticks;

    result_t     awaited_out[$];
    result_t     want;
    result_t     step_out;

    function automatic void clear_counters();
        hdr_count  = '0;
        hdr_bytes  = '0;
        bytes_left = '0;
        idle_ticks = '0;
    endfunction

    // The result is an output argument, so every field is set here.
    function automatic void drop_link(input status_t why, output result_t r);
        link_phase = PH_DISC;
        clear_counters();
        r.status = why;
        r.data   = '0;
        r.last   = 1'b0;
    endfunction

    // Advances the link state by one transaction; returns 1 when it yields a result.
    function automatic bit deframe_predict(input logic [1:0] op, input logic [7:0] b,
                                           output result_t r);
        logic [31:0] len;
        r.status = ST_DATA;
        r.data   = '0;
        r.last   = 1'b0;
        case (op)
            OP_CONNECT:
            begin
                if (link_phase == PH_DISC)
                begin
                    link_phase = PH_HEAD;
                    clear_counters();
                end
                return 1'b0;
            end
            OP_TICK:
            begin
                if (link_phase != PH_PAY)
                    return 1'b0;
                idle_ticks = idle_ticks + 17'd1;
                if (idle_ticks >= {1'b0, tick_limit})
                begin
                    drop_link(ST_TIMEOUT, r);
                    return 1'b1;
                end
                return 1'b0;
            end
            OP_BYTE:
            begin
                if (link_phase == PH_HEAD)
                begin
                    if (hdr_count < 2'd3)
                    begin
                        hdr_bytes = {hdr_bytes[15:0], b};
                        hdr_count = hdr_count + 2'd1;
                        return 1'b0;
                    end
                    // Lengths under four wrap around and look huge.
                    len = {hdr_bytes, b} - HEADER_LEN;
                    if (len > max_len)
                    begin
                        drop_link(ST_TOO_LONG, r);
                        return 1'b1;
                    end
                    if (len == '0)
                    begin
                        drop_link(ST_ZERO, r);
                        return 1'b1;
                    end
                    link_phase = PH_PAY;
                    clear_counters();
                    bytes_left = len;
                    return 1'b0;
                end
                if (link_phase == PH_PAY)
                begin
                    r.data     = b;
                    r.last     = (bytes_left <= 32'd1);
                    idle_ticks = '0;
                    if (r.last)
                    begin
                        link_phase = PH_HEAD;
                        clear_counters();
                    end
                    else
                        bytes_left = bytes_left - 32'd1;
                    return 1'b1;
                end
                return 1'b0;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len     = MAX_PAYLOAD_RESET;
            tick_limit  = PAYLOAD_TIMEOUT_RESET;
            link_phase  = PH_DISC;
            clear_counters();
            awaited_out.delete();
            error_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_out.size() == 0)
                begin
                    $error("unexpected result: status %0d, payload_byte 0x%02h, last %0d",
                           status, payload_byte, last);
                    error_count++;
                end
                else
                begin
                    want = awaited_out.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        error_count++;
                    end
                    if (payload_byte !== want.data)
                    begin
                        $error("payload_byte: expected 0x%02h, got 0x%02h",
                               want.data, payload_byte);
                        error_count++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, last);
                        error_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MAX_PAYLOAD:     max_len    = cfg_data;
                    CFG_PAYLOAD_TIMEOUT: tick_limit = cfg_data[TIMEOUT_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                if (deframe_predict(operation, rx_byte, step_out))
                    awaited_out.push_back(step_out);
            end
        end
        pending = awaited_out.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// Top of the deframer testbench: clock, reset, stimulus and verdict.
// Depends on lpd_pkg, length_prefixed_deframer and lpd_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lpd_pkg::*;

    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam int         CYCLE_LIMIT = 1_000_000;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [1:0]              operation;
    logic [7:0]              rx_byte;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [1:0]              status;
    logic [7:0]              payload_byte;
    logic                    last;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    int          error_count;
    int          pending;
    int          cycle_count = 0;
    int          items_sent = 0;
    int          burst_left = 0;
    bit          gaps_on = 1'b1;
    logic [31:0] cur_max = MAX_PAYLOAD_RESET;
    logic [15:0] cur_timeout = PAYLOAD_TIMEOUT_RESET;
    stall_mode_t stall_mode = STALL_NONE;
    int          stall_hold = 0;

    length_prefixed_deframer DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .payload_byte (payload_byte),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    lpd_checker deframe_chk
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .payload_byte (payload_byte),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .error_count  (error_count),
        .pending      (pending)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL length_prefixed_deframer");
            $finish;
        end
    end

    // The consumer switches between stall patterns, holding each for a random time.
    always @(negedge clk)
    begin
        if (stall_hold == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_hold = $urandom_range(40, 300);
        end
        else
            stall_hold--;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= ((cycle_count % 5) < 2);
        endcase
    end

    task automatic send_op(input logic [1:0] op, input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap        = gaps_on ? $urandom_range(0, 8) : 0;
            burst_left = $urandom_range(1, 20);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid  <= 1'b1;
        operation <= op;
        rx_byte   <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Length word, most significant byte first.
    task automatic send_length(input logic [31:0] word);
        for (int i = 3; i >= 0; i--)
            send_op(OP_BYTE, word[8*i +: 8]);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_MAX_PAYLOAD)
            cur_max = data;
        else
            cur_timeout = data[15:0];
    endtask

    // Drains the block so that registers can be rewritten safely.
    task automatic settle();
        @(negedge clk);
        in_valid  <= 1'b0;
        burst_left = 0;
        wait (pending == 0);
        repeat (4) @(posedge clk);
    endtask

    function automatic int pick_len();
        int cap;
        cap = ($urandom_range(0, 19) == 0) ? 200 : 12;
        if (cur_max < cap)
            cap = int'(cur_max);
        return $urandom_range(1, cap);
    endfunction

    task automatic random_traffic(input int n);
        int          start;
        int          kind;
        int          len;
        int          cut;
        int          ticks;
        logic [32:0] wide;
        start = items_sent;
        while (items_sent - start < n)
        begin
            kind = $urandom_range(0, 99);
            send_op(OP_CONNECT, 8'($urandom));
            if (kind < 60 && cur_max != 0)
            begin
                len = pick_len();
                send_length(32'(len) + HEADER_LEN);
                for (int k = 0; k < len; k++)
                begin
                    if ($urandom_range(0, 11) == 0)
                        send_op(OP_TICK, 8'($urandom));
                    send_op(OP_BYTE, 8'($urandom));
                end
            end
            else if (kind < 72)
            begin
                wide = {1'b0, cur_max} + 33'd1 + 33'($urandom_range(0, 1000));
                if (wide[32] || $urandom_range(0, 3) == 0)
                    send_length($urandom);
                else
                    send_length(wide[31:0] + HEADER_LEN);
            end
            else if (kind < 78)
                send_length(32'($urandom_range(0, 4)));
            else if (kind < 90)
            begin
                // Message cut short, then idle ticks: enough to use up a tick budget of up to 64, else three.
                len = (cur_max == 0) ? 1 : pick_len();
                send_length(32'(len) + HEADER_LEN);
                cut = $urandom_range(0, len - 1);
                for (int k = 0; k < cut; k++)
                    send_op(OP_BYTE, 8'($urandom));
                if (cur_timeout > 64)
                    ticks = 3;
                else
                    ticks = (cur_timeout == 0) ? 1 : int'(cur_timeout);
                repeat (ticks) send_op(OP_TICK, 8'($urandom));
            end
            else
            begin
                repeat ($urandom_range(2, 10))
                    send_op(2'($urandom), 8'($urandom));
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        operation = OP_BYTE;
        rx_byte   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MAX_PAYLOAD;
        cfg_data  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: ignored traffic, one good message and the header errors.
        send_op(OP_BYTE, 8'hA5);
        send_op(OP_TICK, 8'h00);
        send_op(OP_RESERVED, 8'h3C);
        send_op(OP_CONNECT, 8'h00);
        send_length(32'd6);
        send_op(OP_TICK, 8'hFF);
        send_op(OP_BYTE, 8'h00);
        send_op(OP_BYTE, 8'hFF);
        send_op(OP_CONNECT, 8'h00);
        send_length(32'h0001_0005);
        send_op(OP_CONNECT, 8'h00);
        send_length(32'd4);
        send_op(OP_CONNECT, 8'h00);
        send_length(32'd2);
        random_traffic(200);

        // Largest limit: a short length word no longer counts as too long.
        settle();
        write_reg(CFG_MAX_PAYLOAD, 32'hFFFF_FFFF);
        write_reg(CFG_PAYLOAD_TIMEOUT, 32'd2);
        send_op(OP_CONNECT, 8'h00);
        send_length(32'd1);
        send_op(OP_BYTE, 8'h81);
        send_op(OP_CONNECT, 8'h00);
        send_op(OP_TICK, 8'h00);
        send_op(OP_TICK, 8'h00);
        random_traffic(200);

        settle();
        gaps_on = 1'b0;
        write_reg(CFG_MAX_PAYLOAD, 32'd1);
        write_reg(CFG_PAYLOAD_TIMEOUT, 32'd65535);
        random_traffic(200);
        gaps_on = 1'b1;

        // Zero limits: every header fails, either as too long or as empty.
        settle();
        write_reg(CFG_MAX_PAYLOAD, 32'd0);
        write_reg(CFG_PAYLOAD_TIMEOUT, 32'd0);
        send_op(OP_CONNECT, 8'h00);
        send_length(32'd4);
        send_op(OP_CONNECT, 8'h00);
        send_length(32'd5);
        send_op(OP_CONNECT, 8'h00);
        send_length(32'd0);
        random_traffic(150);

        settle();
        write_reg(CFG_MAX_PAYLOAD, 32'd5);
        send_op(OP_CONNECT, 8'h00);
        send_length(32'd6);
        send_op(OP_TICK, 8'h00);
        random_traffic(150);

        repeat (2)
        begin
            settle();
            write_reg(CFG_MAX_PAYLOAD, 32'($urandom_range(1, 300)));
            write_reg(CFG_PAYLOAD_TIMEOUT, 32'($urandom_range(1, 20)));
            random_traffic(270);
        end

        settle();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("PASS length_prefixed_deframer");
        else
            $display("FAIL length_prefixed_deframer");
        $finish;
    end

endmodule
